// File: design/first_fit_partition_allocator_assert.svh
// Assertion macros shared by the partition allocator RTL.
`ifndef FIRST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define FFPA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Check a consequence in the same cycle as its antecedent.
`define FFPA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define FFPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ffpa_pkg.sv
// Types and constants of the first-fit partition allocator.
package ffpa_pkg;

    localparam int FIELD_W = 16;
    localparam int JOB_W = 16;
    localparam int unsigned MEM_SIZE_RESET = 640;

    // Configuration address: byte address 4*i, bit 2 selects the register.
    localparam int PADDR_W = 3;
    localparam logic REG_MEM_SIZE = 1'b0;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } ffpa_op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_ZERO  = 2'd1,
        STATUS_NOFIT = 2'd2,
        STATUS_NOJOB = 2'd3
    } ffpa_status_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_SPLIT_LO,
        ST_SPLIT_HI,
        ST_MERGE_LO,
        ST_MERGE_HI,
        ST_MERGE_WR,
        ST_SHIFT_DN,
        ST_RESULT
    } ffpa_state_t;

    typedef struct packed {
        ffpa_op_t             op;
        logic [JOB_W-1:0]     job_id;
        logic [FIELD_W-1:0]   request_size;
    } ffpa_req_t;

    typedef struct packed {
        ffpa_status_t         status;
        logic [FIELD_W-1:0]   start_address;
        logic [FIELD_W-1:0]   freed_size;
    } ffpa_rsp_t;

endpackage

// File: design/first_fit_partition_allocator.sv
// Top level of the first-fit variable-partition allocator.
//
// The block keeps an address-ordered table of partitions (start, size, busy,
// owner) in one RAM with one write and one registered read port, plus a fill
// count. Entries at or above the count are ignored. Writing memory_size
// (byte address 0) restarts the table as one free partition covering the
// memory. An allocate transfer takes the lowest free partition that is large
// enough: an exact fit is marked busy; otherwise, if the table has room, the
// entries above it move up one slot and the partition is split into a busy
// low part and a free rest. A free transfer releases the lowest busy
// partition of the job and merges it with free neighbors, moving the
// entries above down to close the gap. One request is worked at a time;
// s_ready is high only while the sequencer is idle. The scan reads one
// entry per cycle; after a hit, a split or a free with a merged neighbor
// moves the entries above, and the result then goes to the output register.
// The single RAM read port and the one shared adder set the pace. After
// reset the block writes the initial table entry before the first transfer
// is accepted. A finished result waits in the output register while the
// next request is taken.
`include "first_fit_partition_allocator_assert.svh"

module first_fit_partition_allocator
    import ffpa_pkg::*;
#(
    parameter int MAX_PARTITIONS = 32,
    parameter int SIZE_BITS      = 16
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  ffpa_req_t          s_payload,

    output logic               m_valid,
    input  logic               m_ready,
    output ffpa_rsp_t          m_payload,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W = $clog2(MAX_PARTITIONS);
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
    localparam int ENT_W = 2 * SIZE_BITS + 1 + JOB_W;
    // The adder spans both table sizes and the full 16-bit request.
    localparam int ALU_W = (SIZE_BITS > FIELD_W) ? SIZE_BITS : FIELD_W;

    // Pack one table entry as start, size, busy, owner.
    function automatic logic [ENT_W-1:0] pack_entry(
        input logic [SIZE_BITS-1:0] start,
        input logic [SIZE_BITS-1:0] size,
        input logic                 busy,
        input logic [JOB_W-1:0]     owner
    );
        return {start, size, busy, owner};
    endfunction

    // ---------------------------------------------------------------- state
    ffpa_state_t            state_reg, state_next;
    logic [SIZE_BITS-1:0]   memory_size_reg, memory_size_next;
    logic [CNT_W-1:0]       part_count_reg, part_count_next;
    logic                   pend_reg, pend_next;
    logic                   m_valid_reg, m_valid_next;
    ffpa_rsp_t              m_payload_reg, m_payload_next;

    ffpa_op_t               req_op_reg, req_op_next;
    logic [JOB_W-1:0]       req_job_reg, req_job_next;
    logic [FIELD_W-1:0]     req_need_reg, req_need_next;

    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       k_reg, k_next;
    logic [IDX_W-1:0]       wa_reg, wa_next;
    logic [CNT_W-1:0]       s_reg, s_next;

    logic [SIZE_BITS-1:0]   cur_start_reg, cur_start_next;
    logic [SIZE_BITS-1:0]   cur_size_reg, cur_size_next;
    logic [SIZE_BITS-1:0]   prev_start_reg, prev_start_next;
    logic [SIZE_BITS-1:0]   prev_size_reg, prev_size_next;
    logic                   prev_busy_reg, prev_busy_next;
    logic [SIZE_BITS-1:0]   nxt_size_reg, nxt_size_next;
    logic                   prev_free_reg, prev_free_next;
    logic                   next_free_reg, next_free_next;
    logic [SIZE_BITS-1:0]   acc_reg, acc_next;
    logic [SIZE_BITS-1:0]   rem_reg, rem_next;

    ffpa_status_t           res_status_reg, res_status_next;
    logic [SIZE_BITS-1:0]   res_start_reg, res_start_next;
    logic [SIZE_BITS-1:0]   res_freed_reg, res_freed_next;

    // ---------------------------------------------------------------- table RAM
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENT_W-1:0]       ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ENT_W-1:0]       ram_rdata;

    logic                   core_we;
    logic [IDX_W-1:0]       core_waddr;
    logic [ENT_W-1:0]       core_wdata;

    logic [SIZE_BITS-1:0]   rd_start;
    logic [SIZE_BITS-1:0]   rd_size;
    logic                   rd_busy;
    logic [JOB_W-1:0]       rd_owner;

    assign rd_start = ram_rdata[ENT_W-1 -: SIZE_BITS];
    assign rd_size  = ram_rdata[ENT_W-SIZE_BITS-1 -: SIZE_BITS];
    assign rd_busy  = ram_rdata[JOB_W];
    assign rd_owner = ram_rdata[JOB_W-1:0];

    ffpa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_PARTITIONS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- shared adder
    logic [ALU_W-1:0]       alu_a, alu_b, alu_result;
    logic                   alu_sub, alu_carry;
    logic                   alu_eq;

    ffpa_alu #(
        .WIDTH (ALU_W)
    ) u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .sub    (alu_sub),
        .result (alu_result),
        .carry  (alu_carry)
    );

    assign alu_eq = (alu_result == '0);

    // ---------------------------------------------------------------- config port
    logic                   cfg_wr;
    logic                   cfg_sel;
    logic [SIZE_BITS-1:0]   cfg_size;

    assign cfg_sel  = (paddr[PADDR_W-1:2] == REG_MEM_SIZE);
    assign cfg_wr   = psel && penable && pwrite && cfg_sel;
    assign cfg_size = SIZE_BITS'(pwdata[FIELD_W-1:0]);
    assign pready   = 1'b1;
    assign prdata   = cfg_sel ? 32'(memory_size_reg) : '0;

    // A config write restarts the table and wins the RAM write port.
    always_comb begin
        ram_we    = cfg_wr || core_we;
        ram_waddr = cfg_wr ? '0 : core_waddr;
        ram_wdata = cfg_wr ? pack_entry('0, cfg_size, 1'b0, '0) : core_wdata;
    end

    // ---------------------------------------------------------------- status flags
    logic [CNT_W-1:0]       idx_plus1;
    logic                   scan_last;
    logic                   scan_hit;
    logic                   table_full;
    logic                   shup_more;
    logic                   shdn_more;
    logic                   next_exists;
    logic [1:0]             gap;
    logic [IDX_W-1:0]       target;
    logic                   out_free;

    assign idx_plus1   = CNT_W'(idx_reg) + CNT_W'(1);
    assign scan_last   = (idx_plus1 == part_count_reg);
    assign next_exists = (idx_plus1 < part_count_reg);
    assign table_full  = (part_count_reg == CNT_W'(MAX_PARTITIONS));
    assign shup_more   = (k_reg > idx_reg);
    assign shdn_more   = (s_reg < part_count_reg);
    assign gap         = {1'b0, prev_free_reg} + {1'b0, next_free_reg};
    assign target      = prev_free_reg ? (idx_reg - IDX_W'(1)) : idx_reg;
    assign out_free    = !m_valid_reg || m_ready;

    // Allocate hits a free entry that is large enough; free hits the job's busy entry.
    assign scan_hit = (req_op_reg == OP_ALLOC) ? (!rd_busy && alu_carry)
                                               : (rd_busy && (rd_owner == req_job_reg));

    assign s_ready = (state_reg == ST_IDLE);

    // ---------------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_payload.op == OP_ALLOC && s_payload.request_size == '0) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                priority if (scan_hit && req_op_reg == OP_FREE) begin
                    state_next = ST_MERGE_LO;
                end else if (scan_hit) begin
                    state_next = (alu_eq || table_full) ? ST_RESULT : ST_SHIFT_UP;
                end else if (scan_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_SHIFT_UP: begin
                if (!shup_more && !pend_reg) begin
                    state_next = ST_SPLIT_LO;
                end
            end
            ST_SPLIT_LO: begin
                state_next = ST_SPLIT_HI;
            end
            ST_SPLIT_HI: begin
                state_next = ST_RESULT;
            end
            ST_MERGE_LO: begin
                state_next = ST_MERGE_HI;
            end
            ST_MERGE_HI: begin
                state_next = ST_MERGE_WR;
            end
            ST_MERGE_WR: begin
                state_next = (gap == 2'd0) ? ST_RESULT : ST_SHIFT_DN;
            end
            ST_SHIFT_DN: begin
                if (!shdn_more && !pend_reg) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_comb begin
        memory_size_next = memory_size_reg;
        part_count_next  = part_count_reg;
        pend_next        = pend_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_payload_next   = m_payload_reg;
        req_op_next      = req_op_reg;
        req_job_next     = req_job_reg;
        req_need_next    = req_need_reg;
        idx_next         = idx_reg;
        k_next           = k_reg;
        wa_next          = wa_reg;
        s_next           = s_reg;
        cur_start_next   = cur_start_reg;
        cur_size_next    = cur_size_reg;
        prev_start_next  = prev_start_reg;
        prev_size_next   = prev_size_reg;
        prev_busy_next   = prev_busy_reg;
        nxt_size_next    = nxt_size_reg;
        prev_free_next   = prev_free_reg;
        next_free_next   = next_free_reg;
        acc_next         = acc_reg;
        rem_next         = rem_reg;
        res_status_next  = res_status_reg;
        res_start_next   = res_start_reg;
        res_freed_next   = res_freed_reg;

        core_we    = 1'b0;
        core_waddr = '0;
        core_wdata = '0;
        ram_raddr  = '0;
        alu_a      = ALU_W'(rd_size);
        alu_b      = ALU_W'(req_need_reg);
        alu_sub    = 1'b1;

        unique case (state_reg)
            ST_INIT: begin
                // Seed entry 0 with the whole memory after reset.
                core_we    = 1'b1;
                core_wdata = pack_entry('0, memory_size_reg, 1'b0, '0);
            end
            ST_IDLE: begin
                // Read entry 0 so that the scan starts with its data.
                if (s_valid) begin
                    req_op_next     = s_payload.op;
                    req_job_next    = s_payload.job_id;
                    req_need_next   = s_payload.request_size;
                    idx_next        = '0;
                    res_start_next  = '0;
                    res_freed_next  = '0;
                    res_status_next = STATUS_ZERO;
                end
            end
            ST_SCAN: begin
                // Compare entry idx while the read of idx+1 is under way.
                ram_raddr = idx_reg + IDX_W'(1);
                if (scan_hit) begin
                    cur_start_next = rd_start;
                    cur_size_next  = rd_size;
                    if (req_op_reg == OP_ALLOC) begin
                        priority if (alu_eq) begin
                            core_we         = 1'b1;
                            core_waddr      = idx_reg;
                            core_wdata      = pack_entry(rd_start, rd_size, 1'b1, req_job_reg);
                            res_status_next = STATUS_OK;
                            res_start_next  = rd_start;
                        end else if (table_full) begin
                            res_status_next = STATUS_NOFIT;
                        end else begin
                            k_next    = IDX_W'(part_count_reg - CNT_W'(1));
                            pend_next = 1'b0;
                        end
                    end
                end else begin
                    prev_start_next = rd_start;
                    prev_size_next  = rd_size;
                    prev_busy_next  = rd_busy;
                    if (scan_last) begin
                        res_status_next = (req_op_reg == OP_ALLOC) ? STATUS_NOFIT
                                                                   : STATUS_NOJOB;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_SHIFT_UP: begin
                // Move entries above the hit up one slot, top first.
                ram_raddr = k_reg;
                if (pend_reg) begin
                    core_we    = 1'b1;
                    core_waddr = wa_reg;
                    core_wdata = ram_rdata;
                end
                if (shup_more) begin
                    pend_next = 1'b1;
                    wa_next   = k_reg + IDX_W'(1);
                    k_next    = k_reg - IDX_W'(1);
                end else begin
                    pend_next = 1'b0;
                end
            end
            ST_SPLIT_LO: begin
                alu_a      = ALU_W'(cur_size_reg);
                alu_b      = ALU_W'(req_need_reg);
                alu_sub    = 1'b1;
                rem_next   = SIZE_BITS'(alu_result);
                core_we    = 1'b1;
                core_waddr = idx_reg;
                core_wdata = pack_entry(cur_start_reg, SIZE_BITS'(req_need_reg), 1'b1,
                                        req_job_reg);
            end
            ST_SPLIT_HI: begin
                alu_a           = ALU_W'(cur_start_reg);
                alu_b           = ALU_W'(req_need_reg);
                alu_sub         = 1'b0;
                core_we         = 1'b1;
                core_waddr      = idx_reg + IDX_W'(1);
                core_wdata      = pack_entry(SIZE_BITS'(alu_result), rem_reg, 1'b0, '0);
                part_count_next = part_count_reg + CNT_W'(1);
                res_status_next = STATUS_OK;
                res_start_next  = cur_start_reg;
            end
            ST_MERGE_LO: begin
                // The read data now holds the entry above the released one.
                prev_free_next = (idx_reg != '0) && !prev_busy_reg;
                next_free_next = next_exists && !rd_busy;
                nxt_size_next  = rd_size;
                alu_a          = ALU_W'(cur_size_reg);
                alu_b          = ((idx_reg != '0) && !prev_busy_reg) ? ALU_W'(prev_size_reg)
                                                                     : '0;
                alu_sub        = 1'b0;
                acc_next       = SIZE_BITS'(alu_result);
            end
            ST_MERGE_HI: begin
                alu_a    = ALU_W'(acc_reg);
                alu_b    = next_free_reg ? ALU_W'(nxt_size_reg) : '0;
                alu_sub  = 1'b0;
                acc_next = SIZE_BITS'(alu_result);
            end
            ST_MERGE_WR: begin
                core_we         = 1'b1;
                core_waddr      = target;
                core_wdata      = pack_entry(prev_free_reg ? prev_start_reg : cur_start_reg,
                                             acc_reg, 1'b0, '0);
                k_next          = target + IDX_W'(1);
                s_next          = CNT_W'(target) + CNT_W'(1) + CNT_W'(gap);
                pend_next       = 1'b0;
                res_status_next = STATUS_OK;
                res_freed_next  = cur_size_reg;
            end
            ST_SHIFT_DN: begin
                // Close the gap left by merged entries, bottom first.
                ram_raddr = s_reg[IDX_W-1:0];
                if (pend_reg) begin
                    core_we    = 1'b1;
                    core_waddr = wa_reg;
                    core_wdata = ram_rdata;
                end
                if (shdn_more) begin
                    pend_next = 1'b1;
                    wa_next   = k_reg;
                    k_next    = k_reg + IDX_W'(1);
                    s_next    = s_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        part_count_next = part_count_reg - CNT_W'(gap);
                    end
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next                 = 1'b1;
                    m_payload_next.status        = res_status_reg;
                    m_payload_next.start_address = FIELD_W'(res_start_reg);
                    m_payload_next.freed_size    = FIELD_W'(res_freed_reg);
                end
            end
            default: begin
            end
        endcase

        if (cfg_wr) begin
            memory_size_next = cfg_size;
            part_count_next  = CNT_W'(1);
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_INIT;
            memory_size_reg <= SIZE_BITS'(MEM_SIZE_RESET);
            part_count_reg  <= CNT_W'(1);
            pend_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            memory_size_reg <= memory_size_next;
            part_count_reg  <= part_count_next;
            pend_reg        <= pend_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg  <= m_payload_next;
        req_op_reg     <= req_op_next;
        req_job_reg    <= req_job_next;
        req_need_reg   <= req_need_next;
        idx_reg        <= idx_next;
        k_reg          <= k_next;
        wa_reg         <= wa_next;
        s_reg          <= s_next;
        cur_start_reg  <= cur_start_next;
        cur_size_reg   <= cur_size_next;
        prev_start_reg <= prev_start_next;
        prev_size_reg  <= prev_size_next;
        prev_busy_reg  <= prev_busy_next;
        nxt_size_reg   <= nxt_size_next;
        prev_free_reg  <= prev_free_next;
        next_free_reg  <= next_free_next;
        acc_reg        <= acc_next;
        rem_reg        <= rem_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_freed_reg  <= res_freed_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // ---------------------------------------------------------------- assertions
    `FFPA_ASSERT_ALWAYS(a_count_range, (part_count_reg != '0) && (part_count_reg <= CNT_W'(MAX_PARTITIONS)), "partition count out of range")
    `FFPA_ASSERT_IMPLY(a_split_room, state_reg == ST_SHIFT_UP, !table_full, "split started with a full table")
    `FFPA_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "request taken while another is in work")
    `FFPA_ASSERT_IMPLY(a_free_gap, state_reg == ST_SHIFT_DN, gap != 2'd0, "compaction without a merged neighbor")

endmodule

// File: design/ffpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffpa_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/ffpa_alu.sv
// Shared add/subtract unit; carry out doubles as the a >= b flag on subtract.
module ffpa_alu #(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH-1:0] result,
    output logic             carry
);

    logic [WIDTH-1:0] b_eff;
    logic [WIDTH:0]   sum;

    assign b_eff  = sub ? ~b : b;
    assign sum    = {1'b0, a} + {1'b0, b_eff} + (WIDTH+1)'(sub);
    assign result = sum[WIDTH-1:0];
    assign carry  = sum[WIDTH];

endmodule
